FILE: design/rabin_content_defined_chunker_macros.svh
// ----------------------------------------------------------------------------
// Rabin chunker assertion macros
// Shared property forms for the concurrent checks of the chunker.
// ----------------------------------------------------------------------------
`ifndef RABIN_CONTENT_DEFINED_CHUNKER_MACROS_SVH
`define RABIN_CONTENT_DEFINED_CHUNKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("chunker check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RCDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("chunker check failed one cycle later");

`endif

FILE: design/rcdc_pkg.sv
// ----------------------------------------------------------------------------
// Rabin chunker package
// Word types, register map, reset values and shared helpers.
// ----------------------------------------------------------------------------
package rcdc_pkg;

	localparam int DEFAULT_WINDOW_SIZE = 32;

	// APB register map: 64-bit registers at byte address 8*i.
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [63:0] MULT_RESET = 64'd3;
	localparam logic [63:0] WPOW_RESET = 64'd1853020188851841;
	localparam logic [15:0] DIV_RESET  = 16'd4096;
	localparam logic [15:0] MIN_RESET  = 16'd1024;
	localparam logic [15:0] MAX_RESET  = 16'd8192;

	typedef enum logic [2:0] {
		REG_MULT = 3'd0,
		REG_WPOW = 3'd1,
		REG_DIV  = 3'd2,
		REG_MIN  = 3'd3,
		REG_MAX  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [47:0] chunk_start;
		logic [15:0] chunk_length;
		logic [63:0] chunk_hash;
		logic        is_partial;
	} chunk_t;

	// Which 64-bit product the shared multiplier is working on.
	typedef enum logic [1:0] {
		JOB_SUM  = 2'd0,
		JOB_OUT  = 2'd1,
		JOB_HASH = 2'd2
	} job_t;

	// Which 32x32 partial product of a 64-bit low-half multiply.
	typedef enum logic [1:0] {
		PART_LL = 2'd0,
		PART_LH = 2'd1,
		PART_HL = 2'd2
	} part_t;

	typedef struct packed {
		logic  valid;
		job_t  job;
		part_t part;
	} mul_tag_t;

	function automatic logic [63:0] sext8(input logic [7:0] b);
		return {{56{b[7]}}, b};
	endfunction

endpackage

FILE: design/rcdc_mul.sv
// ----------------------------------------------------------------------------
// Rabin chunker multiplier
// Shared 32x32 multiplier with a registered product and tag.
// ----------------------------------------------------------------------------
module rcdc_mul import rcdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  mul_tag_t    tag,
	output logic [63:0] product_s1,
	output mul_tag_t    tag_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_s1 <= '0;
			tag_s1     <= '0;
		end else begin
			product_s1 <= a * b;
			tag_s1     <= tag;
		end
	end

endmodule

FILE: design/rcdc_rem.sv
// ----------------------------------------------------------------------------
// Rabin chunker remainder unit
// Restoring remainder of a 64-bit value by a 16-bit divisor, two bits a cycle.
// ----------------------------------------------------------------------------
module rcdc_rem import rcdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [15:0] divisor,
	output logic [15:0] remainder,
	output logic        done
);

	logic [63:0] dvd_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] r1;
	logic [16:0] r2;
	logic [15:0] rem1;
	logic [15:0] rem2;

	// Two dependent shift-and-subtract steps per cycle.
	always_comb begin
		r1 = {rem_q, dvd_q[63]};
		if (r1 >= {1'b0, divisor}) begin
			r1 = r1 - {1'b0, divisor};
		end
		rem1 = r1[15:0];
		r2 = {rem1, dvd_q[62]};
		if (r2 >= {1'b0, divisor}) begin
			r2 = r2 - {1'b0, divisor};
		end
		rem2 = r2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				rem_q  <= '0;
				cnt_q  <= 5'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[61:0], 2'b00};
				rem_q <= rem2;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign remainder = rem_q;
	assign done      = done_q;

endmodule

FILE: design/rcdc_window.sv
// ----------------------------------------------------------------------------
// Rabin chunker window store
// Ring of the last stream bytes; each push returns the byte it replaces.
// ----------------------------------------------------------------------------
module rcdc_window import rcdc_pkg::*; #(
	parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);

	localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

	logic [7:0]             mem_q [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0] vld_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [7:0]             rd_q;
	logic                   rd_vld_q;

	// Read of the old byte and write of the new one share the slot.
	always_ff @(posedge clk) begin
		if (push) begin
			rd_q          <= mem_q[slot_q];
			mem_q[slot_q] <= wdata;
		end
	end

	// A slot never written reads as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			slot_q   <= '0;
			rd_vld_q <= 1'b0;
		end else if (push) begin
			rd_vld_q      <= vld_q[slot_q];
			vld_q[slot_q] <= 1'b1;
			if (slot_q == SLOT_W'(WINDOW_SIZE - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 8'h00;

endmodule

FILE: design/rabin_content_defined_chunker.sv
// ----------------------------------------------------------------------------
// Rabin content-defined chunker
// Rolling-sum chunk boundary finder with per-chunk polynomial hash.
//
// The item channel takes one stream byte per word with an end-of-stream flag.
// The chunk channel gives start offset, length, hash and a partial flag for
// every closed chunk. Registers are written over the APB port at 8*i.
// Bytes are taken one at a time: ready falls when a byte is accepted and
// returns once that byte is processed. The shared 32x32 multiplier
// builds the three 64-bit products in turn, and the remainder unit, started
// once the new rolling sum is known, gives the remainder for the boundary
// test. A chunk word becomes valid as ready returns after its last byte.
// A finished chunk sits in an output register, so the next byte is taken
// while the receiver stalls; only when a second chunk closes before the first
// is taken does the block wait in its last cycle. Reset clears the rolling
// sum, chunk state, byte count and window, and loads the register defaults.
// ----------------------------------------------------------------------------
`include "rabin_content_defined_chunker_macros.svh"

module rabin_content_defined_chunker import rcdc_pkg::*; #(
	parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              chunk_valid,
	input  logic              chunk_ready,
	output chunk_t            chunk,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_REM,
		ST_EMIT
	} state_t;

	state_t      state_q;
	job_t        job_q;
	part_t       part_q;
	logic [7:0]  byte_q;
	logic        eos_q;
	logic [63:0] acc_q;
	logic [63:0] sum_q;
	logic [63:0] hash_q;
	logic [15:0] len_q;
	logic [47:0] seen_q;
	logic        chunk_valid_q;
	chunk_t      chunk_q;

	logic [63:0] mult_q;
	logic [63:0] wpow_q;
	logic [15:0] div_q;
	logic [15:0] min_q;
	logic [15:0] max_q;

	reg_idx_t    reg_idx;
	logic        cfg_write;

	logic [7:0]  outgoing;
	logic        push;
	logic [63:0] opa;
	logic [63:0] opb;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	mul_tag_t    mul_tag;
	logic [63:0] product_s1;
	mul_tag_t    tag_s1;
	logic [63:0] shifted;
	logic [63:0] acc_next;
	logic        rem_start;
	logic [15:0] remainder;
	logic        rem_done;

	logic [15:0] len_next;
	logic [47:0] seen_next;
	logic        content;
	logic        boundary;
	logic        emit;
	logic        stall;
	logic        chunk_load;

	// Configuration port.
	assign reg_idx   = reg_idx_t'(paddr[5:3]);
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= MULT_RESET;
			wpow_q <= WPOW_RESET;
			div_q  <= DIV_RESET;
			min_q  <= MIN_RESET;
			max_q  <= MAX_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_MULT: mult_q <= pwdata;
				REG_WPOW: wpow_q <= pwdata;
				REG_DIV:  div_q  <= pwdata[15:0];
				REG_MIN:  min_q  <= pwdata[15:0];
				REG_MAX:  max_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MULT: prdata = mult_q;
			REG_WPOW: prdata = wpow_q;
			REG_DIV:  prdata = {48'h0, div_q};
			REG_MIN:  prdata = {48'h0, min_q};
			REG_MAX:  prdata = {48'h0, max_q};
			default:  prdata = '0;
		endcase
	end

	// Window of recent bytes.
	assign push = item_valid && item_ready;

	rcdc_window #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item.data_byte),
		.rdata  (outgoing)
	);

	// Operand selection for the shared multiplier. The low 64 bits of a
	// 64x64 product need only the low-low, low-high and high-low partials.
	always_comb begin
		unique case (job_q)
			JOB_SUM:  opa = sum_q;
			JOB_OUT:  opa = sext8(outgoing);
			JOB_HASH: opa = hash_q;
			default:  opa = hash_q;
		endcase
		opb   = (job_q == JOB_OUT) ? wpow_q : mult_q;
		mul_a = (part_q == PART_HL) ? opa[63:32] : opa[31:0];
		mul_b = (part_q == PART_LH) ? opb[63:32] : opb[31:0];
	end

	assign mul_tag = '{valid: (state_q == ST_MUL), job: job_q, part: part_q};

	rcdc_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.a          (mul_a),
		.b          (mul_b),
		.tag        (mul_tag),
		.product_s1 (product_s1),
		.tag_s1     (tag_s1)
	);

	// The outgoing-byte product is subtracted from the running sum.
	assign shifted   = (tag_s1.part == PART_LL) ? product_s1 : {product_s1[31:0], 32'h0};
	assign acc_next  = (tag_s1.job == JOB_OUT) ? acc_q - shifted : acc_q + shifted;
	assign rem_start = tag_s1.valid && tag_s1.job == JOB_OUT && tag_s1.part == PART_HL;

	rcdc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (acc_next),
		.divisor   (div_q),
		.remainder (remainder),
		.done      (rem_done)
	);

	// Boundary decision. The remainder is below 2^16, so the multiplier
	// must have its upper bits clear to match.
	assign len_next   = len_q + 16'd1;
	assign seen_next  = seen_q + 48'd1;
	assign content    = (div_q != 16'h0) && (mult_q[63:16] == 48'h0)
		&& (remainder == mult_q[15:0]);
	assign boundary   = ((len_next >= min_q) && content) || (len_next == max_q)
		|| (len_next == 16'hFFFF);
	assign emit       = boundary || eos_q;
	assign stall      = emit && chunk_valid_q && !chunk_ready;
	assign chunk_load = (state_q == ST_EMIT) && emit && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			job_q         <= JOB_SUM;
			part_q        <= PART_LL;
			byte_q        <= '0;
			eos_q         <= 1'b0;
			acc_q         <= '0;
			sum_q         <= '0;
			hash_q        <= '0;
			len_q         <= '0;
			seen_q        <= '0;
			chunk_valid_q <= 1'b0;
			chunk_q       <= '0;
		end else begin
			if (chunk_load) begin
				chunk_valid_q <= 1'b1;
			end else if (chunk_valid_q && chunk_ready) begin
				chunk_valid_q <= 1'b0;
			end

			if (tag_s1.valid) begin
				if (rem_start) begin
					// Rolling sum is complete; start the chunk hash from the byte.
					sum_q <= acc_next;
					acc_q <= sext8(byte_q);
				end else begin
					acc_q <= acc_next;
				end
				if (tag_s1.job == JOB_HASH && tag_s1.part == PART_HL) begin
					hash_q <= acc_next;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						byte_q  <= item.data_byte;
						eos_q   <= item.end_of_stream;
						acc_q   <= sext8(item.data_byte);
						job_q   <= JOB_SUM;
						part_q  <= PART_LL;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					unique case (part_q)
						PART_LL: part_q <= PART_LH;
						PART_LH: part_q <= PART_HL;
						PART_HL: begin
							part_q <= PART_LL;
							if (job_q == JOB_SUM) begin
								job_q <= JOB_OUT;
							end else if (job_q == JOB_OUT) begin
								job_q <= JOB_HASH;
							end else begin
								state_q <= ST_REM;
							end
						end
						default: part_q <= PART_LL;
					endcase
				end
				ST_REM: begin
					if (rem_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!stall) begin
						seen_q  <= seen_next;
						state_q <= ST_IDLE;
						if (emit) begin
							chunk_q <= '{
								chunk_start:  seen_next - {32'h0, len_next},
								chunk_length: len_next,
								chunk_hash:   hash_q,
								is_partial:   !boundary
							};
							len_q  <= '0;
							hash_q <= '0;
						end else begin
							len_q <= len_next;
						end
					end
				end
			endcase
		end
	end

	assign item_ready  = (state_q == ST_IDLE);
	assign chunk_valid = chunk_valid_q;
	assign chunk       = chunk_q;

	`RCDC_ASSERT_SAME(a_idle_mul_quiet, clk, arst_n, item_ready, !tag_s1.valid)
	`RCDC_ASSERT_SAME(a_rem_done_in_wait, clk, arst_n, rem_done, state_q == ST_REM)
	`RCDC_ASSERT_SAME(a_chunk_len_nonzero, clk, arst_n, chunk_valid, chunk.chunk_length != 16'h0)
	`RCDC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && item_ready, !item_ready)

endmodule
